FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of i_clk, idle while reset is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check an implication on every rising edge of i_clk, idle while reset is low.
`define ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

FILE: hw/rtl/thq_pkg.sv
`timescale 1ns / 1ps
package thq_pkg;

    localparam int MAX_TRIANGLES = 4096;
    localparam int COORD_W       = 20;
    localparam int DIFF_W        = COORD_W + 1;
    localparam int OPND_W        = COORD_W + 2;
    localparam int PROD_W        = 2 * OPND_W;
    localparam int TERM_W        = 43;
    localparam int ACC_W         = 64;
    localparam int SPLIT         = 21;
    localparam int COUNT_W       = 13;
    localparam int HEIGHT_W      = 19;
    localparam int VERTEX_W      = 3 * COORD_W;
    localparam int STORE_DEPTH   = 3 * MAX_TRIANGLES;
    localparam int ADDR_W        = $clog2(STORE_DEPTH);
    localparam int STEP_W        = 5;
    localparam int LAST_STEP     = 19;
    localparam int DIV_STEPS     = ACC_W - 1;
    localparam int DCNT_W        = 6;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_PUSH  = 2'd1,
        OP_QUERY = 2'd2
    } t_opcode;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_PUSH = 6'b000010,
        S_LOAD = 6'b000100,
        S_MUL  = 6'b001000,
        S_DIV  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    typedef enum logic [2:0] {
        DST_NONE = 3'd0,
        DST_DET  = 3'd1,
        DST_D1   = 3'd2,
        DST_D2   = 3'd3,
        DST_D3   = 3'd4,
        DST_N1   = 3'd5,
        DST_N2   = 3'd6,
        DST_NUM  = 3'd7
    } t_dst;

    // Control that travels with one product into the accumulator.
    typedef struct packed {
        logic first;
        logic neg;
        logic shift;
        t_dst dst;
    } t_mctl;

endpackage

FILE: hw/rtl/thq_ram.sv
`timescale 1ns / 1ps
module thq_ram #(
    parameter int WIDTH = 60,
    parameter int DEPTH = 12288,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

FILE: hw/rtl/triangle_heightmap_query_top.sv
`timescale 1ns / 1ps
// Triangle height map: store triangles, then ask for the highest surface above a point.
// Input channel (i_valid / o_ready) carries one opcode per transaction: clear empties
// the store, push appends one triangle of three XYZ vertices (signed Q15.4), query
// takes a point (query_x, query_y). Output channel (o_valid / i_ready) returns one
// result per transaction: height, covered, store_full and triangle_total.
// Clear and unknown opcodes go straight to the result, and a full store rejects a push
// the same way; any other push makes three single-port writes into the vertex RAM.
// A query walks every stored triangle through one shared 22x22 multiplier and
// accumulator: it fetches three vertices from the RAM, runs multiply-accumulate for
// determinant, edge signs and interpolation numerator, and then, for each covering
// triangle only, runs the restoring divider. One transaction is in flight at a time.
// The result sits in an output register, so the next transaction is taken while
// it waits; a stalled receiver blocks the block only when a second result is ready.
// Reset (synchronous, active low) empties the store and drops any pending result;
// vertex RAM contents are not cleared, only entries below the count are read.
module triangle_heightmap_query_top
    import thq_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [1:0]                 i_opcode,
    input  logic signed [COORD_W-1:0]  i_vertex_a_x,
    input  logic signed [COORD_W-1:0]  i_vertex_a_y,
    input  logic signed [COORD_W-1:0]  i_vertex_a_z,
    input  logic signed [COORD_W-1:0]  i_vertex_b_x,
    input  logic signed [COORD_W-1:0]  i_vertex_b_y,
    input  logic signed [COORD_W-1:0]  i_vertex_b_z,
    input  logic signed [COORD_W-1:0]  i_vertex_c_x,
    input  logic signed [COORD_W-1:0]  i_vertex_c_y,
    input  logic signed [COORD_W-1:0]  i_vertex_c_z,
    input  logic signed [COORD_W-1:0]  i_query_x,
    input  logic signed [COORD_W-1:0]  i_query_y,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [HEIGHT_W-1:0]        o_height,
    output logic                       o_covered,
    output logic                       o_store_full,
    output logic [COUNT_W-1:0]         o_triangle_total
);

    function automatic logic signed [DIFF_W-1:0] diff(input logic [COORD_W-1:0] a,
                                                      input logic [COORD_W-1:0] b);
        diff = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
    endfunction

    t_state r_state;
    logic [COUNT_W-1:0]        r_count;
    logic [ADDR_W-1:0]         r_wbase;
    logic [ADDR_W-1:0]         r_addr;
    logic [COUNT_W-1:0]        r_tidx;
    logic [1:0]                r_lc;
    logic [STEP_W-1:0]         r_step;
    logic [DCNT_W-1:0]         r_dcnt;
    logic [VERTEX_W-1:0]       r_v [3];
    logic [COORD_W-1:0]        r_px, r_py;
    logic                      r_is_query, r_full, r_cov;
    logic signed [ACC_W-1:0]   r_best;
    logic signed [PROD_W-1:0]  r_prod;
    t_mctl                     r_pctl;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [TERM_W-1:0]  r_det, r_d1, r_d2, r_d3, r_n1, r_n2;
    logic signed [ACC_W-1:0]   r_num;
    logic [ACC_W-2:0]          r_quo;
    logic [TERM_W-1:0]         r_rem;
    logic [TERM_W-1:0]         r_dabs;
    logic                      r_qneg;

    // RAM port
    logic                      ram_we;
    logic [ADDR_W-1:0]         ram_addr;
    logic [VERTEX_W-1:0]       ram_wdata, ram_rdata;

    thq_ram #(.WIDTH(VERTEX_W), .DEPTH(STORE_DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign ram_we    = (r_state == S_PUSH);
    assign ram_addr  = r_addr;
    assign ram_wdata = r_v[r_lc];

    assign o_ready = (r_state == S_IDLE);

    // Vertex fields of the fetched triangle
    logic [COORD_W-1:0] x0, y0, z0, x1, y1, z1, x2, y2, z2;
    assign x0 = r_v[0][COORD_W-1:0];
    assign y0 = r_v[0][2*COORD_W-1:COORD_W];
    assign z0 = r_v[0][3*COORD_W-1:2*COORD_W];
    assign x1 = r_v[1][COORD_W-1:0];
    assign y1 = r_v[1][2*COORD_W-1:COORD_W];
    assign z1 = r_v[1][3*COORD_W-1:2*COORD_W];
    assign x2 = r_v[2][COORD_W-1:0];
    assign y2 = r_v[2][2*COORD_W-1:COORD_W];
    assign z2 = r_v[2][3*COORD_W-1:2*COORD_W];

    // Split a wide term into a low unsigned half and a high signed half.
    function automatic logic signed [OPND_W-1:0] lo_part(input logic signed [TERM_W-1:0] v);
        lo_part = $signed({1'b0, v[SPLIT-1:0]});
    endfunction

    function automatic logic signed [OPND_W-1:0] hi_part(input logic signed [TERM_W-1:0] v);
        hi_part = $signed(v[TERM_W-1:SPLIT]);
    endfunction

    function automatic logic signed [OPND_W-1:0] ext(input logic signed [DIFF_W-1:0] v);
        ext = $signed({v[DIFF_W-1], v});
    endfunction

    // Operand sequencer for the shared multiplier
    logic signed [OPND_W-1:0] mul_a, mul_b;
    t_mctl                    ctl;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        ctl   = '{first: 1'b0, neg: 1'b0, shift: 1'b0, dst: DST_NONE};
        case (r_step)
            5'd0: begin
                mul_a = ext(diff(y1, y2)); mul_b = ext(diff(x0, x2)); ctl.first = 1'b1;
            end
            5'd1: begin
                mul_a = ext(diff(x2, x1)); mul_b = ext(diff(y0, y2)); ctl.dst = DST_DET;
            end
            5'd2: begin
                mul_a = ext(diff(x1, x0)); mul_b = ext(diff(r_py, y0)); ctl.first = 1'b1;
            end
            5'd3: begin
                mul_a = ext(diff(y1, y0)); mul_b = ext(diff(r_px, x0));
                ctl.neg = 1'b1; ctl.dst = DST_D1;
            end
            5'd4: begin
                mul_a = ext(diff(x2, x1)); mul_b = ext(diff(r_py, y1)); ctl.first = 1'b1;
            end
            5'd5: begin
                mul_a = ext(diff(y2, y1)); mul_b = ext(diff(r_px, x1));
                ctl.neg = 1'b1; ctl.dst = DST_D2;
            end
            5'd6: begin
                mul_a = ext(diff(x0, x2)); mul_b = ext(diff(r_py, y2)); ctl.first = 1'b1;
            end
            5'd7: begin
                mul_a = ext(diff(y0, y2)); mul_b = ext(diff(r_px, x2));
                ctl.neg = 1'b1; ctl.dst = DST_D3;
            end
            5'd8: begin
                mul_a = ext(diff(y1, y2)); mul_b = ext(diff(r_px, x2)); ctl.first = 1'b1;
            end
            5'd9: begin
                mul_a = ext(diff(x2, x1)); mul_b = ext(diff(r_py, y2)); ctl.dst = DST_N1;
            end
            5'd10: begin
                mul_a = ext(diff(y2, y0)); mul_b = ext(diff(r_px, x2)); ctl.first = 1'b1;
            end
            5'd11: begin
                mul_a = ext(diff(x0, x2)); mul_b = ext(diff(r_py, y2)); ctl.dst = DST_N2;
            end
            5'd12: begin
                mul_a = lo_part(r_n1); mul_b = ext(diff(z0, z2)); ctl.first = 1'b1;
            end
            5'd13: begin
                mul_a = hi_part(r_n1); mul_b = ext(diff(z0, z2)); ctl.shift = 1'b1;
            end
            5'd14: begin
                mul_a = lo_part(r_n2); mul_b = ext(diff(z1, z2));
            end
            5'd15: begin
                mul_a = hi_part(r_n2); mul_b = ext(diff(z1, z2)); ctl.shift = 1'b1;
            end
            5'd16: begin
                mul_a = lo_part(r_det); mul_b = $signed({{2{z2[COORD_W-1]}}, z2});
            end
            5'd17: begin
                mul_a = hi_part(r_det); mul_b = $signed({{2{z2[COORD_W-1]}}, z2});
                ctl.shift = 1'b1; ctl.dst = DST_NUM;
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    // Accumulate the registered product
    logic signed [ACC_W-1:0] prod_ext, prod_sh, n_acc;
    assign prod_ext = ACC_W'(r_prod);
    assign prod_sh  = r_pctl.shift ? (prod_ext <<< SPLIT) : prod_ext;
    assign n_acc    = (r_pctl.first ? '0 : r_acc) + (r_pctl.neg ? -prod_sh : prod_sh);

    // Inside test and divider helpers
    logic neg_side, pos_side, skip_tri, last_tri;
    logic signed [ACC_W-1:0] num_mag, det_mag, quo_signed;
    logic [TERM_W:0]   shifted;
    logic [TERM_W+1:0] trial;

    assign neg_side = r_d1[TERM_W-1] | r_d2[TERM_W-1] | r_d3[TERM_W-1];
    assign pos_side = (!r_d1[TERM_W-1] && r_d1 != '0) || (!r_d2[TERM_W-1] && r_d2 != '0)
                   || (!r_d3[TERM_W-1] && r_d3 != '0);
    assign skip_tri = (r_det == '0) || (neg_side && pos_side);
    assign last_tri = ((r_tidx + COUNT_W'(1)) == r_count);

    assign num_mag  = r_num[ACC_W-1] ? -r_num : r_num;
    assign det_mag  = r_det[TERM_W-1] ? -ACC_W'(r_det) : ACC_W'(r_det);
    assign shifted  = {r_rem, r_quo[ACC_W-2]};
    assign trial    = {1'b0, shifted} - {2'b0, r_dabs};
    assign quo_signed = r_qneg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_wbase <= '0;
            o_valid <= 1'b0;
            r_pctl  <= '{first: 1'b0, neg: 1'b0, shift: 1'b0, dst: DST_NONE};
        end else begin
            // Retire the output once it is taken, unless a new result replaces it.
            if (o_valid && i_ready && r_state != S_OUT) begin
                o_valid <= 1'b0;
            end

            // Multiply pipeline runs every cycle; only MUL state feeds real control.
            r_prod <= mul_a * mul_b;
            r_pctl <= (r_state == S_MUL) ? ctl
                      : t_mctl'{first: 1'b0, neg: 1'b0, shift: 1'b0, dst: DST_NONE};
            r_acc  <= n_acc;
            case (r_pctl.dst)
                DST_DET: r_det <= n_acc[TERM_W-1:0];
                DST_D1:  r_d1  <= n_acc[TERM_W-1:0];
                DST_D2:  r_d2  <= n_acc[TERM_W-1:0];
                DST_D3:  r_d3  <= n_acc[TERM_W-1:0];
                DST_N1:  r_n1  <= n_acc[TERM_W-1:0];
                DST_N2:  r_n2  <= n_acc[TERM_W-1:0];
                DST_NUM: r_num <= n_acc;
                default: begin
                end
            endcase

            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_is_query <= (i_opcode == OP_QUERY);
                        r_full     <= (i_opcode == OP_PUSH)
                                      && (32'(r_count) >= MAX_TRIANGLES);
                        r_cov      <= 1'b0;
                        r_best     <= '0;
                        r_lc       <= '0;
                        r_px       <= i_query_x;
                        r_py       <= i_query_y;
                        r_v[0]     <= {i_vertex_a_z, i_vertex_a_y, i_vertex_a_x};
                        r_v[1]     <= {i_vertex_b_z, i_vertex_b_y, i_vertex_b_x};
                        r_v[2]     <= {i_vertex_c_z, i_vertex_c_y, i_vertex_c_x};
                        case (i_opcode)
                            OP_CLEAR: begin
                                r_count <= '0;
                                r_wbase <= '0;
                                r_state <= S_OUT;
                            end
                            OP_PUSH: begin
                                if (32'(r_count) >= MAX_TRIANGLES) begin
                                    r_state <= S_OUT;
                                end else begin
                                    r_addr  <= r_wbase;
                                    r_state <= S_PUSH;
                                end
                            end
                            OP_QUERY: begin
                                r_addr     <= '0;
                                r_tidx     <= '0;
                                r_state    <= (r_count != '0) ? S_LOAD : S_OUT;
                            end
                            default: begin
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_PUSH: begin
                    // Write one vertex per cycle.
                    r_addr <= r_addr + ADDR_W'(1);
                    r_lc   <= r_lc + 2'd1;
                    if (r_lc == 2'd2) begin
                        r_count <= r_count + COUNT_W'(1);
                        r_wbase <= r_wbase + ADDR_W'(3);
                        r_state <= S_OUT;
                    end
                end
                S_LOAD: begin
                    if (r_lc != 2'd3) begin
                        r_addr <= r_addr + ADDR_W'(1);
                    end
                    if (r_lc != 2'd0) begin
                        r_v[r_lc - 2'd1] <= ram_rdata;
                    end
                    r_lc <= r_lc + 2'd1;
                    if (r_lc == 2'd3) begin
                        r_step  <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(LAST_STEP)) begin
                        if (skip_tri) begin
                            r_tidx  <= r_tidx + COUNT_W'(1);
                            r_lc    <= '0;
                            r_state <= last_tri ? S_OUT : S_LOAD;
                        end else begin
                            r_rem   <= '0;
                            r_quo   <= num_mag[ACC_W-2:0];
                            r_dabs  <= det_mag[TERM_W-1:0];
                            r_qneg  <= r_num[ACC_W-1] ^ r_det[TERM_W-1];
                            r_dcnt  <= '0;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (r_dcnt != DCNT_W'(DIV_STEPS)) begin
                        // One restoring step per cycle.
                        r_rem  <= trial[TERM_W+1] ? shifted[TERM_W-1:0] : trial[TERM_W-1:0];
                        r_quo  <= {r_quo[ACC_W-3:0], ~trial[TERM_W+1]};
                        r_dcnt <= r_dcnt + DCNT_W'(1);
                    end else begin
                        r_cov <= 1'b1;
                        if (quo_signed > r_best) begin
                            r_best <= quo_signed;
                        end
                        r_tidx  <= r_tidx + COUNT_W'(1);
                        r_lc    <= '0;
                        r_state <= last_tri ? S_OUT : S_LOAD;
                    end
                end
                S_OUT: begin
                    // Hold the result until the output register is free.
                    if (!o_valid || i_ready) begin
                        o_valid          <= 1'b1;
                        o_height         <= r_is_query ? r_best[HEIGHT_W-1:0] : '0;
                        o_covered        <= r_is_query & r_cov;
                        o_store_full     <= r_full;
                        o_triangle_total <= r_count;
                        r_state          <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    logic walking;
    assign walking = (r_state == S_LOAD) || (r_state == S_MUL) || (r_state == S_DIV);

`include "assert_macros.svh"

    `ASSERT_CLK(a_count_max, 32'(r_count) <= MAX_TRIANGLES, "triangle count above capacity")
    `ASSERT_CLK(a_wbase, 32'(r_wbase) == 32'(r_count) * 3, "write base out of step with count")
    `ASSERT_IMPL(a_walk, walking, r_tidx < r_count, "walk index beyond stored triangles")
    `ASSERT_IMPL(a_out_drop, o_valid && i_ready && r_state != S_OUT, ##1 !o_valid, "result kept")

endmodule
